[rtl/ptpob_pkg.sv]
// Shared types and constants for the order book core.
`default_nettype none
package ptpob_pkg;
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;
  localparam logic SIDE_BUY   = 1'b0;
  localparam logic SIDE_SELL  = 1'b1;
  localparam int   FIELD_W    = 32;
  localparam int   COUNT_W    = 7;

  typedef struct packed {
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] price;
    logic [FIELD_W-1:0] qty;
  } entry_t;
endpackage
`default_nettype wire

[rtl/price_time_priority_order_book_core.sv]
// Price-time priority order book: two sorted tables kept in synchronous RAM.
//
//  channel | signals                                    | dir
//  in      | in_valid, in_stall, command, side,         | request in
//          | ord_id, price, quantity                    |
//  out     | out_valid, out_stall, accepted,            | result out
//          | bid_count, ask_count                       |
//
// Each table sits in one memory (one entry per word, one read and one write
// per cycle). An add scans its side from the top for the insert point, then
// shifts the tail up one word at a time; a cancel scans bids then asks for the
// id, then shifts the tail down. The time from the accepting edge to out_valid
// grows with the fill of the table walked (both tables for a cancel), as one
// memory port walks the entries; a rejected add skips the walk.
// Reset (rst, synchronous) clears the fill counts and the control state; the
// memory is not cleared. A waiting result is held in the output register
// while out_stall is high; no new request is taken until it has left.
`default_nettype none
module price_time_priority_order_book_core #(
  parameter int SIDE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic        side,
  input  wire logic [31:0] ord_id,
  input  wire logic [31:0] price,
  input  wire logic [31:0] quantity,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             accepted,
  output logic [6:0]       bid_count,
  output logic [6:0]       ask_count
);
  localparam int AW = (SIDE_DEPTH > 1) ? $clog2(SIDE_DEPTH) : 1;
  localparam int CW = $clog2(SIDE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1; // read issued, compare next
  localparam logic [2:0] ST_SHUP  = 3'd2; // shift tail up for insert
  localparam logic [2:0] ST_SHDN  = 3'd3; // shift tail down for remove
  localparam logic [2:0] ST_DONE  = 3'd4;

  // two memories, one per side
  ptpob_pkg::entry_t bid_mem [SIDE_DEPTH];
  ptpob_pkg::entry_t ask_mem [SIDE_DEPTH];

  logic [2:0]     state;
  logic [CW-1:0]  bid_fill, ask_fill;
  logic           cmd, cur_side;
  ptpob_pkg::entry_t req;
  logic [CW-1:0]  pos;      // entry being read / scanned
  logic [CW-1:0]  tgt;      // insert/remove point
  logic           rd_pend;  // read data valid this cycle
  ptpob_pkg::entry_t rd_data;

  // memory port control (combinational)
  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  ptpob_pkg::entry_t wr_data;
  logic           mem_side; // side of both accesses

  logic [CW-1:0]  cur_fill;
  assign cur_fill = cur_side ? ask_fill : bid_fill;

  // memories: registered read, single write
  always_ff @(posedge clk) begin
    if (wr_en && !mem_side) bid_mem[wr_addr] <= wr_data;
    if (wr_en &&  mem_side) ask_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem_side ? ask_mem[rd_addr] : bid_mem[rd_addr];
  end

  logic ahead, id_hit;
  assign ahead  = cur_side ? (rd_data.price <= req.price) : (rd_data.price >= req.price);
  assign id_hit = (rd_data.id == req.id);

  assign in_stall = (state != ST_IDLE) || out_valid;
  logic take;
  assign take = in_valid && !in_stall;

  always_comb begin
    rd_en = 1'b0; wr_en = 1'b0;
    rd_addr = pos[AW-1:0]; wr_addr = pos[AW-1:0];
    wr_data = req; mem_side = cur_side;
    case (state)
      ST_SCAN: begin
        rd_en = (pos < cur_fill);
      end
      ST_SHUP: begin
        // pos counts down: entry pos-1 read last cycle goes to pos
        if (pos == tgt) begin
          wr_en = 1'b1; wr_addr = tgt[AW-1:0]; wr_data = req;
        end else if (rd_pend) begin
          wr_en = 1'b1; wr_addr = pos[AW-1:0]; wr_data = rd_data;
        end
        rd_addr = AW'(pos - CW'(2));
        rd_en   = (pos > tgt + CW'(1)) || !rd_pend;
        if (!rd_pend) rd_addr = AW'(pos - CW'(1));
      end
      ST_SHDN: begin
        // entry pos read last cycle goes to pos-1
        if (rd_pend) begin
          wr_en = 1'b1; wr_addr = AW'(pos - CW'(1)); wr_data = rd_data;
        end
        rd_addr = AW'(pos + CW'(1));
        rd_en   = (pos + CW'(1) < cur_fill);
        if (!rd_pend) begin
          rd_addr = pos[AW-1:0];
          rd_en   = (pos < cur_fill);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; bid_fill <= '0; ask_fill <= '0;
      out_valid <= 1'b0; rd_pend <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (take) begin
            cmd <= command;
            req <= '{id: ord_id, price: price, qty: quantity};
            pos <= '0; rd_pend <= 1'b0;
            cur_side <= (command == ptpob_pkg::CMD_CANCEL) ? ptpob_pkg::SIDE_BUY : side;
            if (command == ptpob_pkg::CMD_ADD &&
                (price == '0 || quantity == '0 ||
                 (side ? ask_fill : bid_fill) == CW'(SIDE_DEPTH))) begin
              accepted <= 1'b0; state <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // rd_pend: data for entry pos-1 is in rd_data
          if (rd_pend && (cmd == ptpob_pkg::CMD_ADD) && !ahead) begin
            tgt <= pos - CW'(1); pos <= cur_fill; rd_pend <= 1'b0; state <= ST_SHUP;
          end else if (rd_pend && (cmd == ptpob_pkg::CMD_CANCEL) && id_hit) begin
            tgt <= pos - CW'(1); pos <= pos; rd_pend <= 1'b0; state <= ST_SHDN;
          end else if (pos < cur_fill) begin
            pos <= pos + CW'(1); rd_pend <= 1'b1;
          end else if (cmd == ptpob_pkg::CMD_ADD) begin
            tgt <= cur_fill; pos <= cur_fill; rd_pend <= 1'b0; state <= ST_SHUP;
          end else if (cur_side == ptpob_pkg::SIDE_BUY) begin
            cur_side <= ptpob_pkg::SIDE_SELL; pos <= '0; rd_pend <= 1'b0;
          end else begin
            accepted <= 1'b0; state <= ST_DONE;
          end
        end
        ST_SHUP: begin
          if (pos == tgt) begin
            if (cur_side) ask_fill <= ask_fill + CW'(1);
            else          bid_fill <= bid_fill + CW'(1);
            accepted <= 1'b1; state <= ST_DONE;
          end else if (rd_pend) begin
            pos <= pos - CW'(1);
            rd_pend <= (pos > tgt + CW'(1));
          end else begin
            rd_pend <= 1'b1;
          end
        end
        ST_SHDN: begin
          // pos here points at the entry being moved down (starts at tgt+1)
          if (!rd_pend) begin
            if (pos < cur_fill) rd_pend <= 1'b1;
            else begin
              if (cur_side) ask_fill <= ask_fill - CW'(1);
              else          bid_fill <= bid_fill - CW'(1);
              accepted <= 1'b1; state <= ST_DONE;
            end
          end else begin
            pos <= pos + CW'(1);
            rd_pend <= (pos + CW'(1) < cur_fill);
            if (!(pos + CW'(1) < cur_fill)) begin
              if (cur_side) ask_fill <= ask_fill - CW'(1);
              else          bid_fill <= bid_fill - CW'(1);
              accepted <= 1'b1; state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          out_valid <= 1'b1; state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign bid_count = ptpob_pkg::COUNT_W'(bid_fill);
  assign ask_count = ptpob_pkg::COUNT_W'(ask_fill);

`ifndef SYNTH
  // fill never passes the table depth
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    bid_fill <= CW'(SIDE_DEPTH) && ask_fill <= CW'(SIDE_DEPTH))
    else $error("fill count over depth");
  // a rejected request leaves both counts alone
  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !accepted |=> $stable(bid_fill) && $stable(ask_fill))
    else $error("count changed on reject");
  // no request is taken while a result waits
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken with result pending");
`endif
endmodule
`default_nettype wire

[sim/price_time_priority_order_book_core_test.sv]
// Self-checking testbench for the price-time priority order book core.
`default_nettype none
module price_time_priority_order_book_core_test;

  localparam int DEPTH      = 64;
  localparam int IDLE_LIMIT = 40000;

  typedef struct {
    logic       accepted;
    logic [6:0] bid_count;
    logic [6:0] ask_count;
  } book_result_t;

  // Book model plus the queue of results still owed by the block
  class book_scoreboard;
    logic [31:0]  bid_id[$];
    logic [31:0]  bid_px[$];
    logic [31:0]  ask_id[$];
    logic [31:0]  ask_px[$];
    book_result_t owed[$];
    int           errors;

    function void note_request(logic cmd, logic sd, logic [31:0] oid,
                               logic [31:0] px, logic [31:0] qty);
      book_result_t r;
      int pos;
      bit ok;
      ok = 0;
      if (cmd == ptpob_pkg::CMD_ADD) begin
        if (px != 0 && qty != 0) begin
          if (sd == ptpob_pkg::SIDE_BUY && bid_id.size() < DEPTH) begin
            pos = 0;
            while (pos < bid_px.size() && bid_px[pos] >= px) pos++;
            bid_id.insert(pos, oid);
            bid_px.insert(pos, px);
            ok = 1;
          end else if (sd == ptpob_pkg::SIDE_SELL && ask_id.size() < DEPTH) begin
            pos = 0;
            while (pos < ask_px.size() && ask_px[pos] <= px) pos++;
            ask_id.insert(pos, oid);
            ask_px.insert(pos, px);
            ok = 1;
          end
        end
      end else begin
        for (int i = 0; i < bid_id.size() && !ok; i++) if (bid_id[i] == oid) begin
          bid_id.delete(i);
          bid_px.delete(i);
          ok = 1;
        end
        for (int i = 0; i < ask_id.size() && !ok; i++) if (ask_id[i] == oid) begin
          ask_id.delete(i);
          ask_px.delete(i);
          ok = 1;
        end
      end
      r.accepted  = ok;
      r.bid_count = 7'(bid_id.size());
      r.ask_count = 7'(ask_id.size());
      owed.push_back(r);
    endfunction

    task automatic report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task automatic check_result(logic acc, logic [6:0] bc, logic [6:0] sc);
      book_result_t e;
      if (owed.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      e = owed.pop_front();
      if (acc !== e.accepted) report("accepted", acc, e.accepted);
      if (bc !== e.bid_count) report("bid_count", bc, e.bid_count);
      if (sc !== e.ask_count) report("ask_count", sc, e.ask_count);
    endtask
  endclass

  logic        clk, rst;
  logic        in_valid, in_stall, command, side;
  logic [31:0] ord_id, price, quantity;
  logic        out_valid, out_stall, accepted;
  logic [6:0]  bid_count, ask_count;

  book_scoreboard book;
  int  idle_cycles;
  bit  hold_off;
  bit  steady_out;
  logic [31:0] live_ids[$];

  price_time_priority_order_book_core u_top (
    .clk, .rst, .in_valid, .in_stall, .command, .side, .ord_id, .price,
    .quantity, .out_valid, .out_stall, .accepted, .bid_count, .ask_count
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Accept side: record requests, check results and run the watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) book.note_request(command, side, ord_id, price, quantity);
      if (out_valid && !out_stall) book.check_result(accepted, bid_count, ask_count);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("price_time_priority_order_book_core verification failed");
        $finish;
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  initial begin
    int k;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
        for (k = 0; k < 600; k++) @(negedge clk);
        hold_off = 0;
        out_stall <= 0;
      end else if (steady_out) begin
        out_stall <= 0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic send(logic cmd, logic sd, logic [31:0] oid,
                      logic [31:0] px, logic [31:0] qty);
    in_valid <= 1;
    command  <= cmd;
    side     <= sd;
    ord_id   <= oid;
    price    <= px;
    quantity <= qty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (cmd == ptpob_pkg::CMD_ADD && px != 0 && qty != 0) live_ids.push_back(oid);
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(0, 5);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (book.owed.size() != 0) @(negedge clk);
  endtask

  // Price from a narrow band so that ties are common, sometimes the extremes
  function automatic logic [31:0] pick_price();
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFFF;
      1: return 1;
      2: return $urandom;
      default: return 32'd1000 + $urandom_range(0, 15);
    endcase
  endfunction

  task automatic random_request();
    logic [31:0] oid, px, qty;
    int r;
    r   = $urandom_range(0, 99);
    px  = pick_price();
    qty = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 500);
    if (r < 4) px = 0;
    else if (r < 7) qty = 0;
    oid = $urandom;
    if (r >= 55 && r < 90 && live_ids.size() > 0) begin
      int j;
      j = $urandom_range(0, live_ids.size() - 1);
      oid = live_ids[j];
      live_ids.delete(j);
      send(ptpob_pkg::CMD_CANCEL, 1'($urandom_range(0, 1)), oid, $urandom, $urandom);
    end else if (r >= 90) begin
      send(ptpob_pkg::CMD_CANCEL, 1'($urandom_range(0, 1)), oid, px, qty);
    end else begin
      send(ptpob_pkg::CMD_ADD, 1'($urandom_range(0, 1)), oid, px, qty);
    end
  endtask

  initial begin
    int burst;
    book = new();
    hold_off = 0;
    steady_out = 0;
    rst = 1;
    in_valid = 0; command = 0; side = 0;
    ord_id = 0; price = 0; quantity = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: invalid adds, extremes, ties, cancels on both sides
    send(ptpob_pkg::CMD_CANCEL, ptpob_pkg::SIDE_BUY, 32'd5, 0, 0);
    send(ptpob_pkg::CMD_ADD, ptpob_pkg::SIDE_BUY, 32'd1, 0, 32'd10);
    send(ptpob_pkg::CMD_ADD, ptpob_pkg::SIDE_SELL, 32'd2, 32'd10, 0);
    send(ptpob_pkg::CMD_ADD, ptpob_pkg::SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
         32'hFFFF_FFFF);
    send(ptpob_pkg::CMD_ADD, ptpob_pkg::SIDE_BUY, 32'd0, 32'd1, 32'd1);
    send(ptpob_pkg::CMD_ADD, ptpob_pkg::SIDE_BUY, 32'd7, 32'd500, 32'd3);
    send(ptpob_pkg::CMD_ADD, ptpob_pkg::SIDE_BUY, 32'd7, 32'd500, 32'd4);
    send(ptpob_pkg::CMD_ADD, ptpob_pkg::SIDE_SELL, 32'd7, 32'hFFFF_FFFF, 32'd1);
    send(ptpob_pkg::CMD_ADD, ptpob_pkg::SIDE_SELL, 32'd9, 32'd1, 32'hFFFF_FFFF);
    send(ptpob_pkg::CMD_CANCEL, ptpob_pkg::SIDE_SELL, 32'd7, 0, 0);
    send(ptpob_pkg::CMD_CANCEL, ptpob_pkg::SIDE_BUY, 32'd7, 0, 0);
    send(ptpob_pkg::CMD_CANCEL, ptpob_pkg::SIDE_BUY, 32'd7, 0, 0);
    send(ptpob_pkg::CMD_CANCEL, ptpob_pkg::SIDE_BUY, 32'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ptpob_pkg::CMD_CANCEL, ptpob_pkg::SIDE_BUY, 32'd12345, 0, 0);
    drain();

    // Fill both sides past full, with the receiver held off meanwhile
    hold_off = 1;
    for (int i = 0; i < DEPTH + 3; i++) begin
      send(ptpob_pkg::CMD_ADD, ptpob_pkg::SIDE_BUY, 32'h100 + i, pick_price(), 32'd1);
      send(ptpob_pkg::CMD_ADD, ptpob_pkg::SIDE_SELL, 32'h200 + i, pick_price(), 32'd1);
    end
    drain();
    live_ids.delete();
    for (int i = 0; i < DEPTH; i++) begin
      send(ptpob_pkg::CMD_CANCEL, ptpob_pkg::SIDE_SELL, 32'h100 + i, 0, 0);
      send(ptpob_pkg::CMD_CANCEL, ptpob_pkg::SIDE_BUY, 32'h200 + i, 0, 0);
    end
    drain();

    // Random traffic in bursts
    for (int n = 0; n < 520; ) begin
      steady_out = ($urandom_range(0, 7) == 0);
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        random_request();
        n++;
      end
      gap();
    end

    drain();
    repeat (200) @(posedge clk);
    if (book.errors == 0 && book.owed.size() == 0)
      $display("price_time_priority_order_book_core verification clean");
    else
      $display("price_time_priority_order_book_core verification failed");
    $finish;
  end
endmodule
`default_nettype wire
